[rtl/core/ffa_pkg.sv]
package ffa_pkg;

   localparam int unsigned ADDR_W      = 10;
   localparam int unsigned COUNT_W     = 10;
   localparam int unsigned BYTES_W     = 3;
   localparam int unsigned NEED_W      = 14;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned FREE_WORD_W = ADDR_W - 2;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // next word of the last free block
   localparam logic [WORD_W-1:0] LIST_END = 32'h8000_0000;

   localparam logic [NEED_W-1:0] HDR_BYTES  = 14'd8;
   localparam logic [NEED_W-1:0] ALIGN_MASK = 14'd3;

   typedef struct packed {
      logic               cmd;
      logic [COUNT_W-1:0] elem_count;
      logic [BYTES_W-1:0] elem_bytes;
      logic [ADDR_W-1:0]  free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      logic              ok;
   } rsp_type;

   typedef struct packed {
      logic                   cmd;
      logic [COUNT_W-1:0]     count;
      logic [NEED_W-1:0]      need;
      logic [FREE_WORD_W-1:0] free_word;
   } job_type;

   typedef enum logic [3:0] {
      ST_INIT_SIZE,
      ST_INIT_LINK,
      ST_IDLE,
      ST_FREE_WAIT,
      ST_FREE_WRITE,
      ST_WALK,
      ST_LINK_WAIT,
      ST_LINK_NEXT,
      ST_SPLIT_WAIT,
      ST_SPLIT_NEED,
      ST_SPLIT_COUNT,
      ST_EXACT_WAIT,
      ST_EXACT_HEAD,
      ST_EXACT_LINK,
      ST_EXACT_COUNT
   } back_state_type;

endpackage

[rtl/core/first_fit_free_list_allocator.sv]
// First-fit heap allocator over HEAP_BYTES bytes kept as HEAP_BYTES/4 header words in one
// on-chip memory (two read ports, one write port). A request beat either allocates
// elem_count*elem_bytes+8 bytes (rounded up to a word) from the first free block that fits,
// splitting off the upper part of larger blocks, or frees the block under free_address by
// pushing it on the list head; every request gives exactly one response beat. Requests pass
// a register stage and a two-entry queue, so up to three are taken while the engine works.
// After reset the engine writes the whole-heap block's size and link words before it takes
// a request. A free writes the block's link word once its index is reduced; an allocation
// walks the free list (through a wait state when a link must be reduced modulo the heap size),
// then writes three words to split or one or two to unlink; a failed walk ends at the last block.
// The walk is bound by one memory read of a block's size and link per visited block.
module first_fit_free_list_allocator #(
   parameter int unsigned HEAP_BYTES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffa_pkg::rsp_type rsp_data
);
   import ffa_pkg::*;

   localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;

   logic    front_valid;
   job_type front_job;
   logic    queue_full;
   job_type queue_job;
   logic    queue_empty;
   logic    queue_pop;

   ffa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (front_valid),
      .job       (front_job),
      .job_stall (queue_full)
   );

   ffa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_job (front_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_job  (queue_job),
      .empty    (queue_empty)
   );

   ffa_back #(.HEAP_WORDS(HEAP_WORDS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (!queue_empty),
      .job       (queue_job),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/ffa_front.sv]
module ffa_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffa_pkg::req_type req_data,
   output logic             job_valid,
   output ffa_pkg::job_type job,
   input  logic             job_stall
);
   import ffa_pkg::*;

   logic              job_valid_ff, job_valid_in;
   job_type           job_ff, job_in;
   job_type           fresh;
   logic [NEED_W-1:0] payload;
   logic              take;

   // element bytes plus header, rounded up to a word
   assign payload = NEED_W'(req_data.elem_count) * NEED_W'(req_data.elem_bytes);

   always_comb begin
      fresh.cmd       = req_data.cmd;
      fresh.count     = req_data.elem_count;
      fresh.need      = (payload + (HDR_BYTES + ALIGN_MASK)) & ~ALIGN_MASK;
      fresh.free_word = req_data.free_address[ADDR_W-1:2];
   end

   assign req_stall    = job_valid_ff && job_stall;
   assign take         = req_valid && !req_stall;
   assign job_valid_in = take || (job_valid_ff && job_stall);
   assign job_in       = take ? fresh : job_ff;
   assign job_valid    = job_valid_ff;
   assign job          = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

[rtl/core/ffa_queue.sv]
module ffa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ffa_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output ffa_pkg::job_type pop_job,
   output logic             empty
);
   import ffa_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = fill_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign empty   = fill_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/ffa_wrap.sv]
module ffa_wrap #(
   parameter  int unsigned HEAP_WORDS = 256,
   localparam int unsigned IDX_W      = $clog2(HEAP_WORDS)
) (
   input  logic                      clock,
   input  logic [ffa_pkg::WORD_W-1:0] value,
   output logic [IDX_W-1:0]          index
);
   import ffa_pkg::*;

   // reduces a word modulo the heap size in words; the quotient and the remainder are registered in turn
   localparam logic [WORD_W-1:0] RECIP  = WORD_W'((64'd1 << 32) / 64'(HEAP_WORDS));
   localparam int unsigned       QUOT_W = 33 - IDX_W;

   logic [2*WORD_W-1:0] product;
   logic [WORD_W-1:0]   value_ff;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [WORD_W-1:0]   back_mult;
   logic [WORD_W-1:0]   diff;
   logic [IDX_W:0]      rem_ff, rem_in;

   // quotient estimate is at most one low, so the remainder stays below twice the size
   assign product   = 64'(value) * 64'(RECIP);
   assign quot_in   = product[WORD_W +: QUOT_W];
   assign back_mult = WORD_W'(quot_ff) * WORD_W'(HEAP_WORDS);
   assign diff      = value_ff - back_mult;
   assign rem_in    = diff[IDX_W:0];
   assign index     = (rem_ff >= (IDX_W+1)'(HEAP_WORDS)) ?
                      IDX_W'(rem_ff - (IDX_W+1)'(HEAP_WORDS)) : rem_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      value_ff <= value;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

endmodule

[rtl/core/ffa_back.sv]
module ffa_back #(
   parameter  int unsigned HEAP_WORDS = 256,
   localparam int unsigned IDX_W      = $clog2(HEAP_WORDS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_ready,
   input  ffa_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffa_pkg::rsp_type rsp_data
);
   import ffa_pkg::*;

   logic [WORD_W-1:0] heap_mem [HEAP_WORDS];
   logic [WORD_W-1:0] rd_size_ff, rd_link_ff;
   logic [IDX_W-1:0]  rd_addr_a, rd_addr_b;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [IDX_W-1:0]  steps_ff, steps_in;
   logic [WORD_W-1:0] rest_ff, rest_in;
   logic [WORD_W-1:0] link_ff, link_in;
   logic [IDX_W-1:0]  up_ff, up_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              head_valid_ff, head_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [WORD_W-1:0] wrap_value;
   logic [IDX_W-1:0]  wrap_index;
   logic              res_load;
   rsp_type           res;
   logic              out_free;
   logic [WORD_W-1:0] need_word, rest, csize, link;
   logic              fits_split, fits_exact, link_end, link_near, last_step;

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(HEAP_WORDS - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] idx);
      logic [WORD_W-1:0] byte_off;
      byte_off = (WORD_W'(idx) + WORD_W'(1)) << 2;
      return byte_off[ADDR_W-1:0];
   endfunction

   ffa_wrap #(.HEAP_WORDS(HEAP_WORDS)) u_wrap (
      .clock (clock),
      .value (wrap_value),
      .index (wrap_index)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_size_ff <= heap_mem[rd_addr_a];
      rd_link_ff <= heap_mem[rd_addr_b];
   end

   assign csize      = rd_size_ff;
   assign link       = rd_link_ff;
   assign need_word  = WORD_W'(job_ff.need);
   assign rest       = csize - need_word;
   assign fits_split = csize > (need_word + WORD_W'(HDR_BYTES));
   assign fits_exact = csize >= need_word;
   assign link_end   = link[WORD_W-1];
   assign link_near  = link < WORD_W'(HEAP_WORDS);
   assign last_step  = steps_ff == IDX_W'(HEAP_WORDS - 1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      steps_in      = steps_ff;
      rest_in       = rest_ff;
      link_in       = link_ff;
      up_in         = up_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      job_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff;
      mem_wdata     = '0;
      rd_addr_a     = head_ff;
      rd_addr_b     = slot_of(head_ff);
      wrap_value    = '0;
      res_load      = 1'b0;
      res           = '0;

      case (state_ff)
         ST_INIT_SIZE: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = WORD_W'(HEAP_WORDS * 4);
            state_in  = ST_INIT_LINK;
         end
         ST_INIT_LINK: begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(1);
            mem_wdata = LIST_END;
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            if (job_ready && out_free) begin
               job_pop = 1'b1;
               job_in  = job;
               if (job.cmd == CMD_FREE) begin
                  // block starts one word below the given address
                  wrap_value = WORD_W'(job.free_word) + WORD_W'(HEAP_WORDS - 1);
                  state_in   = ST_FREE_WAIT;
               end else if (!head_valid_ff) begin
                  res_load = 1'b1;
               end else begin
                  cur_in        = head_ff;
                  prev_valid_in = 1'b0;
                  steps_in      = '0;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_FREE_WAIT: begin
            state_in = ST_FREE_WRITE;
         end
         ST_FREE_WRITE: begin
            mem_we        = 1'b1;
            mem_waddr     = slot_of(wrap_index);
            mem_wdata     = head_valid_ff ? WORD_W'(head_ff) : LIST_END;
            head_in       = wrap_index;
            head_valid_in = 1'b1;
            res_load      = 1'b1;
            res.ok        = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_WALK: begin
            if (fits_split) begin
               rest_in    = rest;
               wrap_value = WORD_W'(cur_ff) + (rest >> 2);
               state_in   = ST_SPLIT_WAIT;
            end else if (fits_exact) begin
               link_in = link;
               if (prev_valid_ff) begin
                  state_in = ST_EXACT_LINK;
               end else if (link_end) begin
                  head_valid_in = 1'b0;
                  head_in       = '0;
                  state_in      = ST_EXACT_COUNT;
               end else begin
                  wrap_value = link;
                  state_in   = ST_EXACT_WAIT;
               end
            end else begin
               prev_in       = cur_ff;
               prev_valid_in = 1'b1;
               if (link_end || last_step) begin
                  res_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  steps_in = steps_ff + 1'b1;
                  if (link_near) begin
                     // in-range link: next block read goes out right away
                     cur_in    = link[IDX_W-1:0];
                     rd_addr_a = link[IDX_W-1:0];
                     rd_addr_b = slot_of(link[IDX_W-1:0]);
                  end else begin
                     wrap_value = link;
                     state_in   = ST_LINK_WAIT;
                  end
               end
            end
         end
         ST_LINK_WAIT: begin
            state_in = ST_LINK_NEXT;
         end
         ST_LINK_NEXT: begin
            cur_in    = wrap_index;
            rd_addr_a = wrap_index;
            rd_addr_b = slot_of(wrap_index);
            state_in  = ST_WALK;
         end
         ST_SPLIT_WAIT: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = rest_ff;
            state_in  = ST_SPLIT_NEED;
         end
         ST_SPLIT_NEED: begin
            up_in     = wrap_index;
            mem_we    = 1'b1;
            mem_waddr = wrap_index;
            mem_wdata = need_word;
            state_in  = ST_SPLIT_COUNT;
         end
         ST_SPLIT_COUNT: begin
            mem_we            = 1'b1;
            mem_waddr         = slot_of(up_ff);
            mem_wdata         = WORD_W'(job_ff.count);
            res_load          = 1'b1;
            res.ok            = 1'b1;
            res.block_address = addr_of(up_ff);
            state_in          = ST_IDLE;
         end
         ST_EXACT_WAIT: begin
            state_in = ST_EXACT_HEAD;
         end
         ST_EXACT_HEAD: begin
            head_in  = wrap_index;
            state_in = ST_EXACT_COUNT;
         end
         ST_EXACT_LINK: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(prev_ff);
            mem_wdata = link_ff;
            state_in  = ST_EXACT_COUNT;
         end
         ST_EXACT_COUNT: begin
            mem_we            = 1'b1;
            mem_waddr         = slot_of(cur_ff);
            mem_wdata         = WORD_W'(job_ff.count);
            res_load          = 1'b1;
            res.ok            = 1'b1;
            res.block_address = addr_of(cur_ff);
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = res_load ? res : rsp_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT_SIZE;
         prev_valid_ff <= 1'b0;
         steps_ff      <= '0;
         head_ff       <= '0;
         head_valid_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_valid_ff <= prev_valid_in;
         steps_ff      <= steps_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      rest_ff <= rest_in;
      link_ff <= link_in;
      up_ff   <= up_in;
      rsp_ff  <= rsp_in;
   end

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      res_load |-> out_free)
      else $error("result loaded over a beat not yet taken");

   a_first_block_no_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !prev_valid_ff) |-> (steps_ff == '0))
      else $error("walk step count out of step with the previous block");

   a_fail_has_no_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.block_address == '0))
      else $error("failed allocation carries an address");

   a_free_leaves_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE_WRITE) |=> head_valid_ff)
      else $error("free list empty right after a free");

endmodule
